[src/blpm_pkg.sv]
// ----------------------------------------------------------------------------
// blpm_pkg
// Shared codes and command/status types of the binary trie prefix matcher.
// ----------------------------------------------------------------------------
`default_nettype none
package blpm_pkg;
	localparam int LEN_W = 6;
	localparam int VAL_W = 32;
	localparam logic [VAL_W-1:0] NO_VALUE = '1;

	localparam logic [1:0] ACT_INS  = 2'd0;
	localparam logic [1:0] ACT_DEL  = 2'd1;
	localparam logic [1:0] ACT_FIND = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_PRESENCE = 2'd1;
	localparam logic [1:0] ST_NO_NODES = 2'd2;
	localparam logic [1:0] ST_NOT_FND  = 2'd3;

	localparam logic [3:0] CMD_NONE   = 4'd0;
	localparam logic [3:0] CMD_LOAD   = 4'd1;
	localparam logic [3:0] CMD_READ   = 4'd2;
	localparam logic [3:0] CMD_ADV    = 4'd3;
	localparam logic [3:0] CMD_SETVAL = 4'd4;
	localparam logic [3:0] CMD_SETNO  = 4'd5;
	localparam logic [3:0] CMD_FREAD  = 4'd6;
	localparam logic [3:0] CMD_TAKE   = 4'd7;
	localparam logic [3:0] CMD_INIT   = 4'd8;
	localparam logic [3:0] CMD_LINK   = 4'd9;
	localparam logic [3:0] CMD_CLR    = 4'd10;
	localparam logic [3:0] CMD_UREAD  = 4'd11;
	localparam logic [3:0] CMD_UNLINK = 4'd12;
	localparam logic [3:0] CMD_FREE   = 4'd13;

	typedef struct packed {
		logic [3:0] op;
		logic       set_st;
		logic [1:0] st;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0] act;
		logic       val_bad;
		logic       child_zero;
		logic       depth_eq_len;
		logic       depth_eq_kb;
		logic       val_none;
		logic       has_children;
		logic       node_root;
		logic       need_gt_free;
		logic       free_empty;
		logic       last_alloc;
		logic       up_stop;
		logic       count_ok;
	} flags_t;
endpackage
`default_nettype wire

[src/blpm_ctrl.sv]
// ----------------------------------------------------------------------------
// blpm_ctrl
// Sequencer that walks the trie one node access at a time for each operation.
// ----------------------------------------------------------------------------
`default_nettype none
module blpm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire blpm_pkg::flags_t flg,
	output blpm_pkg::cmd_t       cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_FRD  = 4'd3;
	localparam logic [3:0] S_TAKE = 4'd4;
	localparam logic [3:0] S_INIT = 4'd5;
	localparam logic [3:0] S_LINK = 4'd6;
	localparam logic [3:0] S_CLR  = 4'd7;
	localparam logic [3:0] S_URD  = 4'd8;
	localparam logic [3:0] S_UNL  = 4'd9;
	localparam logic [3:0] S_FREE = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	logic [3:0] state_q, state_d;
	logic       out_valid_q, out_valid_d;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		out_valid_d = out_valid_q;
		cmd = '0;
		cmd.op = blpm_pkg::CMD_NONE;
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = blpm_pkg::CMD_LOAD;
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.op = blpm_pkg::CMD_READ;
				state_d = S_CHK;
			end
			S_CHK: begin
				priority if (flg.act == blpm_pkg::ACT_FIND) begin
					cmd.op = blpm_pkg::CMD_ADV;
					state_d = (flg.depth_eq_kb || flg.child_zero) ? S_DONE : S_RD;
				end else if (flg.act == blpm_pkg::ACT_INS) begin
					priority if (flg.val_bad) begin
						cmd.set_st = 1'b1;
						cmd.st = blpm_pkg::ST_PRESENCE;
						state_d = S_DONE;
					end else if (!flg.depth_eq_len && !flg.child_zero) begin
						cmd.op = blpm_pkg::CMD_ADV;
						state_d = S_RD;
					end else if (flg.depth_eq_len) begin
						if (!flg.val_none) begin
							cmd.set_st = 1'b1;
							cmd.st = blpm_pkg::ST_PRESENCE;
						end else begin
							cmd.op = blpm_pkg::CMD_SETVAL;
						end
						state_d = S_DONE;
					end else if (flg.need_gt_free) begin
						cmd.set_st = 1'b1;
						cmd.st = blpm_pkg::ST_NO_NODES;
						state_d = S_DONE;
					end else begin
						state_d = flg.free_empty ? S_TAKE : S_FRD;
					end
				end else if (flg.act == blpm_pkg::ACT_DEL) begin
					priority if (!flg.depth_eq_len) begin
						if (flg.child_zero) begin
							cmd.set_st = 1'b1;
							cmd.st = blpm_pkg::ST_NOT_FND;
							state_d = S_DONE;
						end else begin
							cmd.op = blpm_pkg::CMD_ADV;
							state_d = S_RD;
						end
					end else if (flg.val_none) begin
						cmd.set_st = 1'b1;
						cmd.st = blpm_pkg::ST_PRESENCE;
						state_d = S_DONE;
					end else if (flg.has_children || flg.node_root) begin
						cmd.op = blpm_pkg::CMD_SETNO;
						state_d = S_DONE;
					end else begin
						state_d = S_CLR;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_FRD: begin
				cmd.op = blpm_pkg::CMD_FREAD;
				state_d = S_TAKE;
			end
			S_TAKE: begin
				cmd.op = blpm_pkg::CMD_TAKE;
				state_d = S_INIT;
			end
			S_INIT: begin
				cmd.op = blpm_pkg::CMD_INIT;
				state_d = S_LINK;
			end
			S_LINK: begin
				cmd.op = blpm_pkg::CMD_LINK;
				priority if (flg.last_alloc) begin
					state_d = S_DONE;
				end else begin
					state_d = flg.free_empty ? S_TAKE : S_FRD;
				end
			end
			S_CLR: begin
				cmd.op = blpm_pkg::CMD_CLR;
				state_d = S_URD;
			end
			S_URD: begin
				cmd.op = blpm_pkg::CMD_UREAD;
				state_d = S_UNL;
			end
			S_UNL: begin
				cmd.op = blpm_pkg::CMD_UNLINK;
				state_d = S_FREE;
			end
			S_FREE: begin
				cmd.op = blpm_pkg::CMD_FREE;
				state_d = flg.up_stop ? S_DONE : S_URD;
			end
			S_DONE: begin
				// The result register is free once any waiting transfer completes.
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					out_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end
endmodule
`default_nettype wire

[src/blpm_dp.sv]
// ----------------------------------------------------------------------------
// blpm_dp
// Node memories, root registers, free list and walk registers of the trie.
// ----------------------------------------------------------------------------
`default_nettype none
module blpm_dp #(
	parameter int NODES    = 1024,
	parameter int KEY_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire blpm_pkg::cmd_t               cmd,
	output blpm_pkg::flags_t                  flg,
	input  wire logic [1:0]                   action,
	input  wire logic [31:0]                  key,
	input  wire logic [blpm_pkg::LEN_W-1:0]   prefix_len,
	input  wire logic [blpm_pkg::VAL_W-1:0]   value,
	output logic [1:0]                        status,
	output logic                              matched,
	output logic [blpm_pkg::VAL_W-1:0]        match_value
);
	localparam int IDX_W = $clog2(NODES);
	localparam int CNT_W = IDX_W + 1;
	localparam int LW = blpm_pkg::LEN_W;
	localparam int VW = blpm_pkg::VAL_W;

	logic [IDX_W-1:0] lc_mem [NODES];
	logic [IDX_W-1:0] rc_mem [NODES];
	logic [IDX_W-1:0] pl_mem [NODES];
	logic [VW-1:0]    val_mem [NODES];

	logic [IDX_W-1:0] root_lc_q, root_rc_q;
	logic [VW-1:0]    root_val_q;
	logic [IDX_W-1:0] free_head_q;
	logic [CNT_W-1:0] next_unused_q, free_count_q;

	logic [1:0]          act_q;
	logic [KEY_BITS-1:0] key_q;
	logic [LW-1:0]       len_q, depth_q;
	logic [VW-1:0]       val_q;
	logic [IDX_W-1:0]    node_q, nxt_q, up_q, up_pl_q;
	logic                stop_q;
	logic [1:0]          st_q;
	logic                match_q;
	logic [VW-1:0]       mval_q;

	logic [IDX_W-1:0] rd_addr_q, m_lc, m_rc, m_pl;
	logic [VW-1:0]    m_val;
	logic [IDX_W-1:0] rd_lc, rd_rc, rd_pl, child, other;
	logic [VW-1:0]    rd_val;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             we_lc, we_rc, we_pl, we_val;
	logic [IDX_W-1:0] wr_addr, wd_lc, wd_rc, wd_pl;
	logic [VW-1:0]    wd_val;
	logic [LW-1:0]    len_in;
	logic             kb;

	// Node zero's children and value live in registers so the empty root is defined out of reset.
	assign rd_lc  = (rd_addr_q == '0) ? root_lc_q  : m_lc;
	assign rd_rc  = (rd_addr_q == '0) ? root_rc_q  : m_rc;
	assign rd_pl  = m_pl;
	assign rd_val = (rd_addr_q == '0) ? root_val_q : m_val;
	assign kb     = key_q[KEY_BITS-1];
	assign child  = kb ? rd_rc : rd_lc;
	assign other  = (rd_rc == node_q) ? rd_lc : rd_rc;
	assign len_in = (prefix_len > LW'(KEY_BITS)) ? LW'(KEY_BITS) : prefix_len;

	always_comb begin
		flg.act          = act_q;
		flg.val_bad      = (val_q == blpm_pkg::NO_VALUE);
		flg.child_zero   = (child == '0);
		flg.depth_eq_len = (depth_q == len_q);
		flg.depth_eq_kb  = (depth_q == LW'(KEY_BITS));
		flg.val_none     = (rd_val == blpm_pkg::NO_VALUE);
		flg.has_children = (rd_lc != '0) || (rd_rc != '0);
		flg.node_root    = (node_q == '0);
		flg.need_gt_free = (CNT_W'(len_q - depth_q) > free_count_q);
		flg.free_empty   = (free_head_q == '0);
		flg.last_alloc   = ((depth_q + LW'(1)) == len_q);
		flg.up_stop      = stop_q;
		flg.count_ok     = (free_count_q <= CNT_W'(NODES - 1));
	end

	always_comb begin
		rd_en = 1'b0;
		rd_addr = node_q;
		we_lc = 1'b0;
		we_rc = 1'b0;
		we_pl = 1'b0;
		we_val = 1'b0;
		wr_addr = node_q;
		wd_lc = '0;
		wd_rc = '0;
		wd_pl = node_q;
		wd_val = blpm_pkg::NO_VALUE;
		unique case (cmd.op)
			blpm_pkg::CMD_READ: begin
				rd_en = 1'b1;
			end
			blpm_pkg::CMD_FREAD: begin
				rd_en = 1'b1;
				rd_addr = free_head_q;
			end
			blpm_pkg::CMD_UREAD: begin
				rd_en = 1'b1;
				rd_addr = up_q;
			end
			blpm_pkg::CMD_SETVAL: begin
				we_val = 1'b1;
				wd_val = val_q;
			end
			blpm_pkg::CMD_SETNO, blpm_pkg::CMD_CLR: begin
				we_val = 1'b1;
			end
			blpm_pkg::CMD_INIT: begin
				wr_addr = nxt_q;
				we_lc = 1'b1;
				we_rc = 1'b1;
				we_pl = 1'b1;
				we_val = 1'b1;
				wd_val = ((depth_q + LW'(1)) == len_q) ? val_q : blpm_pkg::NO_VALUE;
			end
			blpm_pkg::CMD_LINK: begin
				we_lc = !kb;
				we_rc = kb;
				wd_lc = nxt_q;
				wd_rc = nxt_q;
			end
			blpm_pkg::CMD_UNLINK: begin
				wr_addr = up_q;
				we_rc = (rd_rc == node_q);
				we_lc = (rd_rc != node_q);
			end
			blpm_pkg::CMD_FREE: begin
				we_rc = 1'b1;
				wd_rc = free_head_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			m_lc <= lc_mem[rd_addr];
			m_rc <= rc_mem[rd_addr];
			m_pl <= pl_mem[rd_addr];
			m_val <= val_mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (wr_addr != '0) begin
			if (we_lc) lc_mem[wr_addr] <= wd_lc;
			if (we_rc) rc_mem[wr_addr] <= wd_rc;
			if (we_pl) pl_mem[wr_addr] <= wd_pl;
			if (we_val) val_mem[wr_addr] <= wd_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_lc_q <= '0;
			root_rc_q <= '0;
			root_val_q <= blpm_pkg::NO_VALUE;
			free_head_q <= '0;
			next_unused_q <= CNT_W'(1);
			free_count_q <= CNT_W'(NODES - 1);
		end else begin
			if (wr_addr == '0) begin
				if (we_lc) root_lc_q <= wd_lc;
				if (we_rc) root_rc_q <= wd_rc;
				if (we_val) root_val_q <= wd_val;
			end
			if (cmd.op == blpm_pkg::CMD_TAKE) begin
				if (free_head_q != '0) begin
					free_head_q <= rd_rc;
				end else begin
					next_unused_q <= next_unused_q + CNT_W'(1);
				end
				free_count_q <= free_count_q - CNT_W'(1);
			end
			if (cmd.op == blpm_pkg::CMD_FREE) begin
				free_head_q <= node_q;
				free_count_q <= free_count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			blpm_pkg::CMD_LOAD: begin
				act_q <= action;
				key_q <= key[KEY_BITS-1:0];
				len_q <= len_in;
				val_q <= value;
				depth_q <= '0;
				node_q <= '0;
				st_q <= blpm_pkg::ST_OK;
				match_q <= 1'b0;
				mval_q <= blpm_pkg::NO_VALUE;
			end
			blpm_pkg::CMD_ADV: begin
				if (act_q == blpm_pkg::ACT_FIND && rd_val != blpm_pkg::NO_VALUE) begin
					match_q <= 1'b1;
					mval_q <= rd_val;
				end
				node_q <= child;
				depth_q <= depth_q + LW'(1);
				key_q <= key_q << 1;
			end
			blpm_pkg::CMD_TAKE: begin
				nxt_q <= (free_head_q != '0) ? free_head_q : next_unused_q[IDX_W-1:0];
			end
			blpm_pkg::CMD_LINK: begin
				node_q <= nxt_q;
				depth_q <= depth_q + LW'(1);
				key_q <= key_q << 1;
			end
			blpm_pkg::CMD_CLR: begin
				up_q <= rd_pl;
			end
			blpm_pkg::CMD_UNLINK: begin
				stop_q <= (other != '0) || (rd_val != blpm_pkg::NO_VALUE) || (up_q == '0);
				up_pl_q <= rd_pl;
			end
			blpm_pkg::CMD_FREE: begin
				node_q <= up_q;
				up_q <= up_pl_q;
			end
			default: begin
			end
		endcase
		if (cmd.set_st) begin
			st_q <= cmd.st;
		end
		if (cmd.load_out) begin
			status <= st_q;
			matched <= match_q;
			match_value <= mval_q;
		end
	end
endmodule
`default_nettype wire

[src/binary_trie_longest_prefix_match.sv]
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match
// Longest prefix match over a binary trie with insert, delete and find.
// ----------------------------------------------------------------------------
// An item on the input channel (in_valid/in_stall) is an insert, delete or
// find; each gives exactly one result on the output channel
// (out_valid/out_stall). One item is worked at a time; in_stall is high
// from the transfer until the result sits in the output register.
// Every trie level costs one node memory read and one check.
// An insert adds, per new node, a read of the free list head when that
// list is not empty, then a take, an init and a link; a delete that
// frees nodes adds a clear of the value, then a read, an unlink and a
// free for each freed node on the walk back up. The next item can be
// taken in the cycle after the result is loaded. A result waiting under
// out_stall does not block the next input item from being taken. Reset
// empties the trie: the root has no children and no value, and all
// other nodes are free. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module binary_trie_longest_prefix_match #(
	parameter int NODES    = 1024,
	parameter int KEY_BITS = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [1:0]                 action,
	input  wire logic [31:0]                key,
	input  wire logic [blpm_pkg::LEN_W-1:0] prefix_len,
	input  wire logic [blpm_pkg::VAL_W-1:0] value,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [1:0]                      status,
	output logic                            matched,
	output logic [blpm_pkg::VAL_W-1:0]      match_value
);
	blpm_pkg::cmd_t   cmd;
	blpm_pkg::flags_t flg;

	blpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.flg       (flg),
		.cmd       (cmd)
	);

	blpm_dp #(
		.NODES    (NODES),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.flg         (flg),
		.action      (action),
		.key         (key),
		.prefix_len  (prefix_len),
		.value       (value),
		.status      (status),
		.matched     (matched),
		.match_value (match_value)
	);

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		flg.count_ok)
		else $error("free node count exceeds node capacity");

	a_match_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && matched |-> status == blpm_pkg::ST_OK)
		else $error("a match came with a failing status");

	a_nomatch_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !matched |-> match_value == blpm_pkg::NO_VALUE)
		else $error("no match but a value was returned");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> in_stall)
		else $error("result loaded outside the end of an operation");
`endif
endmodule
`default_nettype wire
